// File: rtl/core/shsort_pkg.sv
// Shared types and constants of the Shell sort block.
`default_nettype none

package shsort_pkg;

  // Width of one element, fixed by the channel payload.
  localparam int VALUE_W = 32;

  // One-cycle commands from the controller to the datapath. At most one is high.
  typedef struct packed {
    logic load;         // take the input transaction into the buffer
    logic sort_init;    // first gap is half the element count
    logic pass_next;    // halve the gap and restart the pass
    logic fetch_issue;  // read the element at the pass index
    logic fetch_take;   // hold that element and read its gapped neighbour
    logic cmp_shift;    // move the neighbour up one gap and read the next one down
    logic place;        // drop the held element into the hole, advance the index
    logic emit_init;    // rewind the emit index
    logic emit_rd;      // read the next sorted element
    logic emit_ld;      // load the output register
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic gap_zero;     // every pass is done
    logic n_lt_cnt;     // the pass index still lies inside the batch
    logic greater;      // neighbour is strictly greater than the held element
    logic jn_ge_gap;    // after a shift the hole can still move down
    logic k_last;       // emit index points at the final element
    logic out_free;     // output register can take a result next cycle
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/shsort_in_if.sv
// Input channel of the Shell sort block: one element per transaction.
`default_nettype none

interface shsort_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [shsort_pkg::VALUE_W-1:0] item_value;
  logic                               item_last;

  modport source (output valid, output item_value, output item_last, input ready);
  modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/shsort_out_if.sv
// Result channel of the Shell sort block: one sorted element per transaction.
`default_nettype none

interface shsort_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [shsort_pkg::VALUE_W-1:0] sorted_value;
  logic                               sorted_last;
  logic                               overflow;

  modport source (output valid, output sorted_value, output sorted_last, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input sorted_last, input overflow,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/shsort_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module shsort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/shsort_ctrl.sv
// Sequencing state machine of the Shell sort block: load, sort passes, emit.
`default_nettype none

module shsort_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire shsort_pkg::stat_t stat,
  output shsort_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_NEXT    = 3'd2;
  localparam logic [2:0] S_FETCH   = 3'd3;
  localparam logic [2:0] S_CMP     = 3'd4;
  localparam logic [2:0] S_PLACE   = 3'd5;
  localparam logic [2:0] S_EMIT_RD = 3'd6;
  localparam logic [2:0] S_EMIT_LD = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.sort_init = 1'b1;
        state_nxt     = S_NEXT;
      end
      S_NEXT: begin
        if (stat.gap_zero) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else if (stat.n_lt_cnt) begin
          cmd.fetch_issue = 1'b1;
          state_nxt       = S_FETCH;
        end else begin
          cmd.pass_next = 1'b1;
        end
      end
      S_FETCH: begin
        cmd.fetch_take = 1'b1;
        state_nxt      = S_CMP;
      end
      S_CMP: begin
        if (stat.greater) begin
          cmd.cmp_shift = 1'b1;
          state_nxt     = stat.jn_ge_gap ? S_CMP : S_PLACE;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_NEXT;
      end
      S_EMIT_RD: begin
        if (stat.out_free) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = stat.k_last ? S_LOAD : S_EMIT_RD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/shsort_dp.sv
// Datapath of the Shell sort block: element buffer, indices, compare and output register.
`default_nettype none

module shsort_dp #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire shsort_pkg::cmd_t                   cmd,
  input  wire logic signed [shsort_pkg::VALUE_W-1:0] in_value,
  input  wire logic                               out_ready,
  output shsort_pkg::stat_t                       stat,
  output logic                                    out_valid,
  output logic signed [shsort_pkg::VALUE_W-1:0]   out_value,
  output logic                                    out_last,
  output logic                                    out_ovf
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int VW = shsort_pkg::VALUE_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic          ovf_r,  ovf_nxt;
  logic [AW-1:0] gap_r,  gap_nxt;
  logic [CW-1:0] n_r,    n_nxt;
  logic [AW-1:0] j_r,    j_nxt;
  logic [AW-1:0] k_r,    k_nxt;
  logic [VW-1:0] cur_r,  cur_nxt;
  logic          oval_r, oval_nxt;
  logic [VW-1:0] oval_data_r, oval_data_nxt;
  logic          olast_r, olast_nxt;
  logic          oovf_r, oovf_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] rd_data;
  logic [AW-1:0] jn;
  logic [CW-1:0] half_cnt;

  shsort_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign jn       = j_r - gap_r;
  assign half_cnt = cnt_r >> 1;

  always_comb begin
    stat.gap_zero  = (gap_r == '0);
    stat.n_lt_cnt  = (n_r < cnt_r);
    stat.greater   = ($signed(rd_data) > $signed(cur_r));
    stat.jn_ge_gap = (jn >= gap_r);
    stat.k_last    = ((CW'(k_r) + CW'(1)) == cnt_r);
    stat.out_free  = !oval_r || out_ready;
  end

  // Memory port steering.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_r;
    wr_data = cur_r;
    rd_en   = 1'b0;
    rd_addr = k_r;
    if (cmd.load) begin
      wr_en   = (cnt_r < MAX_CNT);
      wr_addr = cnt_r[AW-1:0];
      wr_data = in_value;
    end
    if (cmd.cmp_shift) begin
      wr_en   = 1'b1;
      wr_data = rd_data;
      rd_en   = stat.jn_ge_gap;
      rd_addr = jn - gap_r;
    end
    if (cmd.place) begin
      wr_en = 1'b1;
    end
    if (cmd.fetch_issue) begin
      rd_en   = 1'b1;
      rd_addr = n_r[AW-1:0];
    end
    if (cmd.fetch_take) begin
      rd_en   = 1'b1;
      rd_addr = n_r[AW-1:0] - gap_r;
    end
    if (cmd.emit_rd) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    gap_nxt       = gap_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    oval_nxt      = oval_r && !out_ready;
    oval_data_nxt = oval_data_r;
    olast_nxt     = olast_r;
    oovf_nxt      = oovf_r;
    if (cmd.load) begin
      if (cnt_r < MAX_CNT) begin
        cnt_nxt = cnt_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.sort_init) begin
      gap_nxt = half_cnt[AW-1:0];
      n_nxt   = half_cnt;
    end
    if (cmd.pass_next) begin
      gap_nxt = gap_r >> 1;
      n_nxt   = CW'(gap_r >> 1);
    end
    if (cmd.fetch_take) begin
      cur_nxt = rd_data;
      j_nxt   = n_r[AW-1:0];
    end
    if (cmd.cmp_shift) begin
      j_nxt = jn;
    end
    if (cmd.place) begin
      n_nxt = n_r + CW'(1);
    end
    if (cmd.emit_init) begin
      k_nxt = '0;
    end
    if (cmd.emit_ld) begin
      oval_nxt      = 1'b1;
      oval_data_nxt = rd_data;
      olast_nxt     = stat.k_last;
      oovf_nxt      = ovf_r;
      k_nxt         = k_r + AW'(1);
      if (stat.k_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gap_r       <= gap_nxt;
    n_r         <= n_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    cur_r       <= cur_nxt;
    oval_data_r <= oval_data_nxt;
    olast_r     <= olast_nxt;
    oovf_r      <= oovf_nxt;
  end

  assign out_valid = oval_r;
  assign out_value = $signed(oval_data_r);
  assign out_last  = olast_r;
  assign out_ovf   = oovf_r;

endmodule

`default_nettype wire

// File: rtl/core/shell_sort_halving_gaps_top.sv
// Top level of the Shell sort block: channels, controller, datapath and checks.
`default_nettype none

// Shell sort of one batch of signed 32-bit elements using the halving gap
// sequence. Elements arrive one per input transaction; the transaction with
// item_last set closes the batch and starts the sort. Up to MAX_ITEMS
// elements are kept; any further elements are dropped and every result of
// that batch then carries overflow, while a dropped element that has
// item_last set still closes the batch. After sorting, the elements leave in
// ascending order, one per result transaction, and the final one has
// sorted_last set. Loading never stalls the sender. The sort runs on one
// buffer RAM with one write and one registered read port; it has a set-up
// step, a gap-halving step per pass, a step to leave the sort once the gap
// reaches zero, a fetch, a neighbour read and a placing step for every
// index of every pass, and a shift step for each element moved down a gap.
// Each result is read from the buffer, then loaded into the output register
// once that is free. The input channel accepts nothing while a batch is
// being sorted or emitted, but a new batch may start loading while the last
// result still waits in the output register. No clearing pass is needed
// after reset: only buffer entries written in the current batch are ever read.

module shell_sort_halving_gaps_top #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  shsort_in_if.sink     in_ch,
  shsort_out_if.source  out_ch
);

  shsort_pkg::cmd_t  cmd;
  shsort_pkg::stat_t stat;

  logic                               dp_out_valid;
  logic signed [shsort_pkg::VALUE_W-1:0] dp_out_value;
  logic                               dp_out_last;
  logic                               dp_out_ovf;
  logic                               ctrl_in_ready;

  // The controller issues at most one datapath command per cycle.
  shsort_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.item_last),
    .in_ready (ctrl_in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the buffer, the gap and index registers and the
  // output register that parts the sort from the consumer.
  shsort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_ch.item_value),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .out_valid (dp_out_valid),
    .out_value (dp_out_value),
    .out_last  (dp_out_last),
    .out_ovf   (dp_out_ovf)
  );

  assign in_ch.ready         = ctrl_in_ready;
  assign out_ch.valid        = dp_out_valid;
  assign out_ch.sorted_value = dp_out_value;
  assign out_ch.sorted_last  = dp_out_last;
  assign out_ch.overflow     = dp_out_ovf;

  // The controller never issues two commands in the same cycle.
  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // A result is never loaded over one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> !(out_ch.valid && !out_ch.ready))
    else $error("output register overwritten before its transaction");

  // Closing a batch stops the input channel while the batch is sorted.
  a_close_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.item_last) |=> !in_ch.ready)
    else $error("input accepted right after the batch was closed");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the Shell sort block, with its own predictor and randomised flow control.

module tb_top;

  // Buffer depth given to the block, and the flow-control and drain constants.
  localparam int DEPTH           = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS    = 40;
  localparam int LINGER_CYCLES   = 200;
  localparam int VALUE_W         = shsort_pkg::VALUE_W;

  typedef logic signed [VALUE_W-1:0] elem_t;

  // One sorted element as the result channel should present it.
  typedef struct packed {
    elem_t value;
    logic  last;
    logic  ovf;
  } sorted_elem_t;

  logic clk;
  logic rst_n;

  shsort_in_if  in_ch ();
  shsort_out_if out_ch ();

  shell_sort_halving_gaps_top #(.MAX_ITEMS(DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The clock toggles every half period of four time units.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Predictor state: the elements of the batch being gathered, how many are held
  // and whether anything has been dropped, plus the sorted elements still owed.
  elem_t          held [DEPTH];
  int             held_count;
  bit             batch_dropped;
  sorted_elem_t   expected_elems [$];

  // Elements of the next batch that the sender is to offer, in order.
  elem_t          pending_batch [$];

  int             fail_count;
  int             random_sent;

  // When set, neither side idles, so that long stretches run at full rate.
  bit             no_idle;

  // The stimulus asks for a long receiver hold-off by bumping hold_requests;
  // the receiver process counts the stall out itself and bumps holds_served.
  int             hold_requests;
  int             holds_served;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Shell sort over the held elements with the halving gap sequence. Each pass
  // is a gapped insertion sort that only moves an element past strictly
  // greater ones, so equal values keep their order within a pass.
  function automatic void shell_sort_held(int cnt);
    int    gap;
    int    n;
    int    j;
    elem_t cur;
    for (gap = cnt / 2; gap > 0; gap = gap / 2) begin
      for (n = gap; n < cnt; n++) begin
        cur = held[n];
        j = n;
        while (j >= gap && held[j - gap] > cur) begin
          held[j] = held[j - gap];
          j -= gap;
        end
        held[j] = cur;
      end
    end
  endfunction

  // Takes one accepted input transaction. Elements beyond the buffer depth are
  // dropped and mark the batch; a closing element, dropped or not, sorts the
  // held elements and queues them as the results owed for this batch.
  function automatic void gather_element(elem_t value, logic last);
    sorted_elem_t e;
    if (held_count < DEPTH) begin
      held[held_count] = value;
      held_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (last) begin
      shell_sort_held(held_count);
      for (int k = 0; k < held_count; k++) begin
        e.value = held[k];
        e.last  = (k == held_count - 1);
        e.ovf   = batch_dropped;
        expected_elems.push_back(e);
      end
      held_count    = 0;
      batch_dropped = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------

  // Both channels are sampled at the rising edge, where the values driven at
  // the previous falling edge are stable. A result transaction always belongs
  // to a batch closed earlier, so checking it before gathering the input
  // transaction of the same edge keeps the expectation order intact.
  always @(posedge clk) begin : channel_monitor
    sorted_elem_t want;
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_elems.size() == 0) begin
          $error("unexpected result transaction: sorted_value %0d, sorted_last %0b",
                 out_ch.sorted_value, out_ch.sorted_last);
          fail_count++;
        end else begin
          want = expected_elems.pop_front();
          if (out_ch.sorted_value !== want.value) begin
            $error("sorted_value mismatch: expected %0d, got %0d",
                   want.value, out_ch.sorted_value);
            fail_count++;
          end
          if (out_ch.sorted_last !== want.last) begin
            $error("sorted_last mismatch: expected %0b, got %0b",
                   want.last, out_ch.sorted_last);
            fail_count++;
          end
          if (out_ch.overflow !== want.ovf) begin
            $error("overflow mismatch: expected %0b, got %0b",
                   want.ovf, out_ch.overflow);
            fail_count++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        gather_element(in_ch.item_value, in_ch.item_last);
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------------

  // Idle length: usually none, often a few cycles, now and then a long one.
  function automatic int idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_idle)
      return 0;
    else if (pick < 55)
      return 0;
    else if (pick < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  // The receiver drives ready at each falling edge, exactly once per edge. A
  // stall is counted down here, whether it is a random one or the long
  // hold-off that the stimulus asks for.
  initial begin : receiver
    int stall_left;
    int stall;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        stall = idle_length();
        if (stall == 0 || $urandom_range(0, 99) < 40) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = stall - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one element from a falling edge, holds it until the rising edge at
  // which it is taken, and returns at the next falling edge. valid is left
  // high so that a following element can go straight out.
  task automatic send_element(elem_t value, logic last);
    in_ch.valid      <= 1'b1;
    in_ch.item_value <= value;
    in_ch.item_last  <= last;
    do
      @(posedge clk);
    while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Sends the pending batch with its final element marked, idling at random
  // between transactions. valid is only lowered at an edge where nothing new
  // is offered.
  task automatic send_batch();
    int gap;
    for (int i = 0; i < pending_batch.size(); i++) begin
      send_element(pending_batch[i], i == pending_batch.size() - 1);
      gap = idle_length();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    pending_batch.delete();
  endtask

  // Random element: full-range values, tight clusters that produce ties,
  // the extremes, and values of every magnitude with either sign.
  function automatic elem_t random_element();
    int unsigned pick;
    elem_t       v;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      v = $urandom;
    end else if (pick < 65) begin
      v = $signed($urandom_range(0, 8)) - 4;
    end else if (pick < 80) begin
      case ($urandom_range(0, 5))
        0:       v = {1'b1, {(VALUE_W-1){1'b0}}};
        1:       v = {1'b0, {(VALUE_W-1){1'b1}}};
        2:       v = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
        3:       v = {1'b0, {(VALUE_W-2){1'b1}}, 1'b0};
        4:       v = '1;
        default: v = '0;
      endcase
    end else begin
      v = $signed($urandom >> $urandom_range(1, 31));
      if ($urandom_range(0, 1) == 1)
        v = -v;
    end
    return v;
  endfunction

  task automatic fill_random_batch(int count);
    repeat (count) pending_batch.push_back(random_element());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A batch of one element is closed by that element and sorts to itself.
  task automatic test_single_element_batches();
    pending_batch.push_back({1'b1, {(VALUE_W-1){1'b0}}});
    send_batch();
    pending_batch.push_back({1'b0, {(VALUE_W-1){1'b1}}});
    send_batch();
    pending_batch.push_back('0);
    send_batch();
  endtask

  // Both ends of the signed range and the values around zero, in an order
  // that makes every pass move something.
  task automatic test_extreme_values();
    pending_batch.push_back({1'b0, {(VALUE_W-1){1'b1}}});
    pending_batch.push_back('0);
    pending_batch.push_back({1'b1, {(VALUE_W-1){1'b0}}});
    pending_batch.push_back('1);
    pending_batch.push_back(1);
    pending_batch.push_back({1'b0, {(VALUE_W-2){1'b1}}, 1'b0});
    pending_batch.push_back({1'b1, {(VALUE_W-2){1'b0}}, 1'b1});
    send_batch();
  endtask

  // Ties must not be reordered, and an already sorted pair must stay put.
  task automatic test_equal_values();
    pending_batch = '{5, -3, 5, 5, -3, 5, 0};
    send_batch();
    pending_batch = '{-1, 1};
    send_batch();
  endtask

  // Exactly a buffer's worth of elements: the store is full, nothing dropped.
  task automatic test_full_buffer();
    fill_random_batch(DEPTH);
    send_batch();
  endtask

  // More elements than the buffer holds. The closing element is itself
  // dropped, yet it still ends the batch, and every result carries overflow.
  task automatic test_overflow_drops();
    fill_random_batch(DEPTH + 1);
    send_batch();
    fill_random_batch(DEPTH + 6);
    send_batch();
    // The flag must clear again for the batch that follows.
    fill_random_batch(3);
    send_batch();
  endtask

  // No idling on either side for a run of small batches.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (6) begin
      fill_random_batch($urandom_range(1, 12));
      send_batch();
    end
    no_idle = 1'b0;
  endtask

  // The receiver holds ready low for a long stretch while the sender keeps
  // offering batches, so the output register fills and the input stalls.
  task automatic test_output_hold_off();
    hold_requests++;
    repeat (3) begin
      fill_random_batch($urandom_range(4, 10));
      send_batch();
    end
  endtask

  // Random batches, mostly small, some large, a few beyond the buffer depth.
  task automatic test_random_batches();
    int unsigned pick;
    int          count;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        count = $urandom_range(1, 8);
      else if (pick < 90)
        count = $urandom_range(9, 24);
      else if (pick < 96)
        count = $urandom_range(25, DEPTH);
      else
        count = $urandom_range(DEPTH + 1, DEPTH + 8);
      // Every tenth batch or so runs without any idling.
      no_idle = ($urandom_range(0, 9) == 0);
      fill_random_batch(count);
      send_batch();
      random_sent += count;
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    fail_count       = 0;
    random_sent      = 0;
    held_count       = 0;
    batch_dropped    = 1'b0;
    no_idle          = 1'b0;
    hold_requests    = 0;
    holds_served     = 0;
    in_ch.valid      = 1'b0;
    in_ch.item_value = '0;
    in_ch.item_last  = 1'b0;
    rst_n            = 1'b0;

    // Reset is held low from the start and released at a falling edge.
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_single_element_batches();
    test_extreme_values();
    test_equal_values();
    test_full_buffer();
    test_overflow_drops();
    test_back_to_back();
    test_output_hold_off();
    test_random_batches();

    in_ch.valid <= 1'b0;

    // Drain every owed result, then linger so that a stray extra result would
    // still be caught by the monitor.
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (LINGER_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the long hold-off.
  initial begin : watchdog
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
